// File: sv/ncc_pkg.sv
// ============================================================================
// Nearest-centroid classifier package
// Shared types and constants for the classifier datapath and its channels.
// ============================================================================
package ncc_pkg;

    localparam int VAL_W  = 16;
    localparam int SQ_W   = 32;
    localparam int DIST_W = 36;
    localparam int CFG_W  = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Item opcodes.
    localparam logic OP_CENTROID = 1'b0;
    localparam logic OP_SAMPLE   = 1'b1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_NUM_CLUSTERS = 1'b0;
    localparam logic REG_NUM_DIMS     = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [3:0]              cluster_select;
        logic [3:0]              dim_select;
        logic signed [VAL_W-1:0] element_value;
    } ncc_item_t;

    typedef struct packed {
        logic [3:0]        best_cluster;
        logic [DIST_W-1:0] best_distance;
    } ncc_result_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic rd_en;
        logic acc_en;
        logic clear;
    } ncc_ctrl_t;

endpackage

// File: sv/ncc_item_if.sv
// ============================================================================
// Input channel interface
// Valid/ready channel carrying one centroid or sample element per word.
// ============================================================================
interface ncc_item_if;
    import ncc_pkg::*;

    logic      valid;
    logic      ready;
    ncc_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ncc_result_if.sv
// ============================================================================
// Result channel interface
// Valid/ready channel carrying one classification result per word.
// ============================================================================
interface ncc_result_if;
    import ncc_pkg::*;

    logic        valid;
    logic        ready;
    ncc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ncc_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module ncc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/ncc_cell.sv
// ============================================================================
// Classifier cell
// Holds one centroid row and its running distance, and takes part in the
// running minimum that moves one cell further along the row each cycle.
// ============================================================================
module ncc_cell #(
    parameter int MAX_DIMS   = 16,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0,
    parameter int AW         = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ncc_pkg::ncc_ctrl_t              ctrl,
    input  logic                            active,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   addr,
    input  logic signed [ncc_pkg::VAL_W-1:0] wdata,
    input  logic signed [ncc_pkg::VAL_W-1:0] sample,
    input  logic [IDX_W-1:0]                cand_in_idx,
    input  logic [ncc_pkg::DIST_W-1:0]      cand_in_dist,
    output logic [IDX_W-1:0]                cand_out_idx,
    output logic [ncc_pkg::DIST_W-1:0]      cand_out_dist
);
    import ncc_pkg::*;

    logic signed [VAL_W-1:0] centroid;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          diff_abs;
    logic [VAL_W-1:0]        mag;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIST_W-1:0]       sum_reg;
    logic [DIST_W-1:0]       sum_next;
    logic [DIST_W-1:0]       base;
    logic [DIST_W:0]         total;
    logic [IDX_W-1:0]        cand_idx_reg;
    logic [DIST_W-1:0]       cand_dist_reg;

    ncc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIMS)
    ) u_row (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (addr),
        .rdata (centroid)
    );

    // Magnitude of the difference fits 16 bits, so the square fits 32.
    always_comb
    begin
        diff     = {sample[VAL_W-1], sample} - {centroid[VAL_W-1], centroid};
        diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;
        mag      = diff_abs[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= mag * mag;
    end

    always_comb
    begin
        base     = ctrl.clear ? '0 : sum_reg;
        total    = {1'b0, base} + (DIST_W + 1)'(sq_reg);
        sum_next = sum_reg;
        if (ctrl.acc_en)
        begin
            if (active)
            begin
                sum_next = (total > {1'b0, DIST_MAX}) ? DIST_MAX : total[DIST_W-1:0];
            end
            else if (ctrl.clear)
            begin
                sum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Strictly smaller wins, so the lower index keeps a tie.
    always_ff @(posedge clk)
    begin
        if (active && (sum_reg < cand_in_dist))
        begin
            cand_idx_reg  <= IDX_W'(CELL_INDEX);
            cand_dist_reg <= sum_reg;
        end
        else
        begin
            cand_idx_reg  <= cand_in_idx;
            cand_dist_reg <= cand_in_dist;
        end
    end

    assign cand_out_idx  = cand_idx_reg;
    assign cand_out_dist = cand_dist_reg;
endmodule

// File: sv/nearest_centroid_classifier.sv
// ============================================================================
// Nearest-centroid classifier
// Row of cells, one per cluster, each holding its centroid and distance.
// ============================================================================
//
//  Channel   Dir  Word                                  Notes
//  items     in   opcode, cluster_select, dim_select,   centroid write or
//                 element_value                         sample element
//  results   out  best_cluster, best_distance           one per sample
//  APB       in   num_clusters (0x0), num_dims (0x4)    pready always high
//
// A centroid write is taken without leaving the idle state. A sample element
// passes through the centroid row read, the squaring in every cell and the
// saturating accumulate; no new item is taken meanwhile. On the last
// dimension the running minimum then walks the row of MAX_CLUSTERS cells,
// one cell a cycle, and the result is loaded into the output register once
// it is free. A sample element with dimension not below num_dims is dropped.
// Reset clears all running distances and the centroid-loaded flag; the
// centroid storage holds nothing defined until written.
// A stalled result only holds the block when the next result is ready.
//
// ============================================================================
module nearest_centroid_classifier #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    ncc_item_if.sink            items,
    ncc_result_if.source        results,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ncc_pkg::*;

    localparam int AW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int IDX_W   = $clog2(MAX_CLUSTERS);
    localparam int CNT_W   = $clog2(MAX_CLUSTERS);
    localparam int CLUS_CAP = (MAX_CLUSTERS > 31) ? 31 : MAX_CLUSTERS;
    localparam int DIMS_CAP = (MAX_DIMS > 31) ? 31 : MAX_DIMS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        scan_cnt_reg;
    logic [CNT_W-1:0]        scan_cnt_next;
    logic [CFG_W-1:0]        num_clusters_reg;
    logic [CFG_W-1:0]        num_dims_reg;
    logic                    loaded_reg;
    logic                    clear_reg;
    logic                    last_reg;
    logic signed [VAL_W-1:0] sample_reg;
    logic                    out_valid_reg;
    ncc_result_t             out_data_reg;

    logic                    accept;
    logic                    centroid_ok;
    logic                    sample_ok;
    logic                    cfg_wr;
    logic [CFG_W-1:0]        cfg_val;
    logic [AW-1:0]           addr;
    logic                    load_out;
    ncc_ctrl_t               ctrl;

    logic [MAX_CLUSTERS-1:0] active;
    logic [MAX_CLUSTERS-1:0] wr_en;
    logic [IDX_W-1:0]        chain_idx  [MAX_CLUSTERS+1];
    logic [DIST_W-1:0]       chain_dist [MAX_CLUSTERS+1];

    // ------------------------------------------------------------------
    // Configuration registers. The low five bits of a write saturate into their legal ranges.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = pwdata[CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg <= CFG_W'(2);
            num_dims_reg     <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NUM_CLUSTERS)
            begin
                if (cfg_val < CFG_W'(2))
                begin
                    num_clusters_reg <= CFG_W'(2);
                end
                else if (32'(cfg_val) > MAX_CLUSTERS)
                begin
                    num_clusters_reg <= CFG_W'(CLUS_CAP);
                end
                else
                begin
                    num_clusters_reg <= cfg_val;
                end
            end
            else
            begin
                if (cfg_val < CFG_W'(1))
                begin
                    num_dims_reg <= CFG_W'(1);
                end
                else if (32'(cfg_val) > MAX_DIMS)
                begin
                    num_dims_reg <= CFG_W'(DIMS_CAP);
                end
                else
                begin
                    num_dims_reg <= cfg_val;
                end
            end
        end
    end

    assign prdata = (paddr[2] == REG_NUM_DIMS) ? 32'(num_dims_reg) : 32'(num_clusters_reg);

    // ------------------------------------------------------------------
    // Input decode. Centroid writes go straight to the selected cell's
    // row; a sample element in range launches the row read in all cells.
    // ------------------------------------------------------------------
    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;
    assign addr        = AW'(items.data.dim_select);

    assign centroid_ok = (items.data.opcode == OP_CENTROID)
                      && (32'(items.data.cluster_select) < MAX_CLUSTERS)
                      && (32'(items.data.dim_select) < MAX_DIMS);
    assign sample_ok   = (items.data.opcode == OP_SAMPLE)
                      && ({1'b0, items.data.dim_select} < num_dims_reg);

    always_comb
    begin
        ctrl.rd_en  = accept && sample_ok;
        ctrl.acc_en = (state_reg == S_ACC);
        ctrl.clear  = clear_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= items.data.element_value;
            clear_reg  <= (items.data.dim_select == 4'd0);
            last_reg   <= ({1'b0, items.data.dim_select} == (num_dims_reg - CFG_W'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
        end
        else if (accept && centroid_ok)
        begin
            loaded_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && sample_ok)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                scan_cnt_next = '0;
                state_next    = last_reg ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(MAX_CLUSTERS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Row of cells. The minimum enters at cell zero seeded with the
    // largest distance and index zero, so a saturated cluster zero
    // still reports itself.
    // ------------------------------------------------------------------
    assign chain_idx[0]  = '0;
    assign chain_dist[0] = DIST_MAX;

    for (genvar j = 0; j < MAX_CLUSTERS; j++)
    begin : g_cell
        assign active[j] = (32'(num_clusters_reg) > j);
        assign wr_en[j]  = accept && centroid_ok && (32'(items.data.cluster_select) == j);

        ncc_cell #(
            .MAX_DIMS   (MAX_DIMS),
            .IDX_W      (IDX_W),
            .CELL_INDEX (j)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .active        (active[j]),
            .wr_en         (wr_en[j]),
            .addr          (addr),
            .wdata         (items.data.element_value),
            .sample        (sample_reg),
            .cand_in_idx   (chain_idx[j]),
            .cand_in_dist  (chain_dist[j]),
            .cand_out_idx  (chain_idx[j+1]),
            .cand_out_dist (chain_dist[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register. Without any centroid written the result is zero.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (loaded_reg)
            begin
                out_data_reg.best_cluster  <= 4'(chain_idx[MAX_CLUSTERS]);
                out_data_reg.best_distance <= chain_dist[MAX_CLUSTERS];
            end
            else
            begin
                out_data_reg.best_cluster  <= '0;
                out_data_reg.best_distance <= '0;
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

`ifndef SYNTHESIS
    // A new result is only ever loaded from the final sequencer state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg) == S_DONE)
        else $error("result appeared outside the done state");

    // An accepted in-range sample always starts the multiply step.
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample_ok) |=> (state_reg == S_MUL))
        else $error("accepted sample did not enter the multiply step");

    // The cluster count never leaves its legal range.
    a_clusters_range: assert property (@(posedge clk) disable iff (!rst_n)
        (num_clusters_reg >= CFG_W'(2)) && (32'(num_clusters_reg) <= MAX_CLUSTERS))
        else $error("num_clusters out of range");
`endif
endmodule
